@@ design/hcat_pkg.sv @@
// Shared types and codes for the atom unique table.
// Used by hcat_ctrl, hcat_dp and hash_consing_atom_table; no dependencies.
package hcat_pkg;

	localparam int CMD_W  = 3;
	localparam int KIND_W = 2;
	localparam int RES_W  = 3;

	// Command codes carried by an input item
	typedef enum logic [CMD_W-1:0] {
		CMD_GET     = 3'd0,
		CMD_FIND    = 3'd1,
		CMD_GET_EQ  = 3'd2,
		CMD_FIND_EQ = 3'd3,
		CMD_TRUNC   = 3'd4,
		CMD_CLEAR   = 3'd5
	} cmd_t;

	// Result status codes
	typedef enum logic [RES_W-1:0] {
		RES_FOUND    = 3'd0,
		RES_CREATED  = 3'd1,
		RES_NOTFOUND = 3'd2,
		RES_FULL     = 3'd3,
		RES_DONE     = 3'd4
	} res_t;

	// Controller states
	typedef enum logic [3:0] {
		S_INIT,
		S_INIT_DRAIN,
		S_IDLE,
		S_DECODE,
		S_PRD,
		S_PCHK,
		S_ACHK,
		S_SWEEP,
		S_DRAIN,
		S_RESP
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic sweep_start;
		logic sweep_run;
		logic sweep_fin;
		logic create;
		logic next_slot;
		logic res_we;
		res_t res_code;
		logic out_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_lookup;
		logic is_find;
		logic is_trunc;
		logic is_clear;
		logic trunc_eff;
		logic slot_empty;
		logic atom_match;
		logic probes_last;
		logic table_full;
		logic sweep_last;
	} dp_sts_t;

endpackage

@@ design/hcat_ctrl.sv @@
// Controller state machine of the atom unique table.
// Depends on hcat_pkg; drives hcat_dp through dp_cmd_t.
module hcat_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output hcat_pkg::dp_cmd_t cmd,
	input  hcat_pkg::dp_sts_t sts
);
	import hcat_pkg::*;

	state_t state_q, state_nx;
	logic   out_valid_q;

	// State register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_INIT:       if (sts.sweep_last) state_nx = S_INIT_DRAIN;
			S_INIT_DRAIN: state_nx = S_IDLE;
			S_IDLE:       if (in_valid) state_nx = S_DECODE;
			S_DECODE: begin
				if (sts.is_lookup)
					state_nx = S_PRD;
				else if (sts.is_clear || (sts.is_trunc && sts.trunc_eff))
					state_nx = S_SWEEP;
				else
					state_nx = S_RESP;
			end
			S_PRD:        state_nx = S_PCHK;
			S_PCHK:       state_nx = sts.slot_empty ? S_RESP : S_ACHK;
			S_ACHK: begin
				if (sts.atom_match || sts.probes_last)
					state_nx = S_RESP;
				else
					state_nx = S_PRD;
			end
			S_SWEEP:      if (sts.sweep_last) state_nx = S_DRAIN;
			S_DRAIN:      state_nx = S_RESP;
			S_RESP:       if (!out_valid_q || !out_stall) state_nx = S_IDLE;
			default:      state_nx = S_INIT;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		cmd.res_code = RES_DONE;
		unique case (state_q)
			S_INIT:       cmd.sweep_run = 1'b1;
			S_INIT_DRAIN: cmd.sweep_fin = 1'b1;
			S_IDLE:       cmd.load = in_valid;
			S_DECODE: begin
				if (!sts.is_lookup) begin
					cmd.sweep_start = 1'b1;
					cmd.res_we      = 1'b1;
				end
			end
			S_PCHK: begin
				if (sts.slot_empty) begin
					cmd.res_we = 1'b1;
					if (sts.is_find)
						cmd.res_code = RES_NOTFOUND;
					else if (sts.table_full)
						cmd.res_code = RES_FULL;
					else begin
						cmd.res_code = RES_CREATED;
						cmd.create   = 1'b1;
					end
				end
			end
			S_ACHK: begin
				if (sts.atom_match) begin
					cmd.res_we   = 1'b1;
					cmd.res_code = RES_FOUND;
				end else if (sts.probes_last) begin
					cmd.res_we   = 1'b1;
					cmd.res_code = sts.is_find ? RES_NOTFOUND : RES_FULL;
				end else
					cmd.next_slot = 1'b1;
			end
			S_SWEEP:      cmd.sweep_run = 1'b1;
			S_DRAIN:      cmd.sweep_fin = 1'b1;
			S_RESP:       cmd.out_load = !out_valid_q || !out_stall;
			default:      cmd = '0;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ design/hcat_dp.sv @@
// Datapath of the atom unique table: hash slot memory, atom memory,
// probe and sweep counters, result registers. Depends on hcat_pkg.
module hcat_dp #(
	parameter int MAX_ATOMS  = 1024,
	parameter int HASH_SLOTS = 2048,
	parameter int VAR_BITS   = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [hcat_pkg::CMD_W-1:0]        command,
	input  logic [hcat_pkg::KIND_W-1:0]       op_kind,
	input  logic [VAR_BITS-1:0]               left_var,
	input  logic [VAR_BITS-1:0]               right_var,
	input  logic [$clog2(MAX_ATOMS+1)-1:0]    keep_count,
	input  hcat_pkg::dp_cmd_t                 cmd,
	output hcat_pkg::dp_sts_t                 sts,
	output logic [$clog2(MAX_ATOMS)-1:0]      atom_index,
	output logic [hcat_pkg::RES_W-1:0]        status
);
	import hcat_pkg::*;

	localparam int IDX_W  = $clog2(MAX_ATOMS);
	localparam int CNT_W  = $clog2(MAX_ATOMS + 1);
	localparam int SLOT_W = $clog2(HASH_SLOTS);
	localparam int KEY_W  = KIND_W + 2 * VAR_BITS;

	// Item registers
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [CNT_W-1:0]    keep_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   probes_q;
	logic [CNT_W-1:0]    count_q;

	// Sweep control
	logic [SLOT_W-1:0]   sw_q;
	logic [SLOT_W-1:0]   swa_s1;
	logic                swv_s1;
	logic                zero_all_q;

	// Memories
	logic [CNT_W-1:0]    hmem [HASH_SLOTS];
	logic [KEY_W-1:0]    amem [MAX_ATOMS];
	logic [CNT_W-1:0]    hrd_q;
	logic [KEY_W-1:0]    ard_q;

	// Results
	logic [IDX_W-1:0]    res_idx_q, atom_index_q;
	res_t                res_status_q;
	logic [RES_W-1:0]    status_q;

	// Input normalization and hash fold
	logic                eq_in, swap_in;
	logic [KIND_W-1:0]   nkind;
	logic [VAR_BITS-1:0] nleft, nright;
	logic [KEY_W-1:0]    nkey;
	logic [SLOT_W-1:0]   fold;
	logic [SLOT_W-1:0]   hash_slot;

	always_comb begin
		int j;
		eq_in   = (command == CMD_GET_EQ) || (command == CMD_FIND_EQ);
		swap_in = eq_in && (left_var > right_var);
		nkind   = eq_in ? '0 : op_kind;
		nleft   = swap_in ? right_var : left_var;
		nright  = swap_in ? left_var : right_var;
		nkey    = {nkind, nleft, nright};
		fold    = '0;
		j       = 0;
		for (int i = 0; i < KEY_W; i++) begin
			fold[j] = fold[j] ^ nkey[i];
			j = (j == SLOT_W - 1) ? 0 : j + 1;
		end
		if ({1'b0, fold} >= (SLOT_W + 1)'(HASH_SLOTS))
			hash_slot = fold - SLOT_W'(HASH_SLOTS);
		else
			hash_slot = fold;
	end

	// Memory ports
	logic [SLOT_W-1:0] h_ra, h_wa;
	logic [CNT_W-1:0]  h_wd, hrd_m1;
	logic              h_we;
	logic [IDX_W-1:0]  a_ra;

	always_comb begin
		h_ra   = cmd.sweep_run ? sw_q : slot_q;
		hrd_m1 = hrd_q - CNT_W'(1);
		a_ra   = hrd_m1[IDX_W-1:0];
		if (swv_s1) begin
			h_we = 1'b1;
			h_wa = swa_s1;
			h_wd = (zero_all_q || (hrd_q > keep_q)) ? '0 : hrd_q;
		end else begin
			h_we = cmd.create;
			h_wa = slot_q;
			h_wd = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (h_we)
			hmem[h_wa] <= h_wd;
		hrd_q <= hmem[h_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.create)
			amem[count_q[IDX_W-1:0]] <= key_q;
		ard_q <= amem[a_ra];
	end

	// Item capture and probe walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= command;
			key_q    <= nkey;
			keep_q   <= keep_count;
			slot_q   <= hash_slot;
			probes_q <= '0;
		end else if (cmd.next_slot) begin
			slot_q   <= (slot_q == SLOT_W'(HASH_SLOTS - 1)) ? '0 : slot_q + SLOT_W'(1);
			probes_q <= probes_q + SLOT_W'(1);
		end
	end

	// Atom count and sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sw_q       <= '0;
			swa_s1     <= '0;
			swv_s1     <= 1'b0;
			zero_all_q <= 1'b1;
		end else begin
			swv_s1 <= cmd.sweep_run;
			swa_s1 <= sw_q;
			if (cmd.sweep_start) begin
				sw_q       <= '0;
				zero_all_q <= (cmd_q == CMD_CLEAR);
			end else if (cmd.sweep_run)
				sw_q <= sw_q + SLOT_W'(1);
			if (cmd.sweep_fin)
				count_q <= zero_all_q ? '0 : keep_q;
			else if (cmd.create)
				count_q <= count_q + CNT_W'(1);
		end
	end

	// Result and output registers
	always_ff @(posedge clk) begin
		if (cmd.res_we) begin
			res_status_q <= cmd.res_code;
			case (cmd.res_code)
				RES_FOUND:   res_idx_q <= a_ra;
				RES_CREATED: res_idx_q <= count_q[IDX_W-1:0];
				default:     res_idx_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			atom_index_q <= res_idx_q;
			status_q     <= res_status_q;
		end
	end

	// Status to controller
	always_comb begin
		sts.is_lookup   = (cmd_q == CMD_GET) || (cmd_q == CMD_FIND) ||
		                  (cmd_q == CMD_GET_EQ) || (cmd_q == CMD_FIND_EQ);
		sts.is_find     = (cmd_q == CMD_FIND) || (cmd_q == CMD_FIND_EQ);
		sts.is_trunc    = (cmd_q == CMD_TRUNC);
		sts.is_clear    = (cmd_q == CMD_CLEAR);
		sts.trunc_eff   = (keep_q < count_q);
		sts.slot_empty  = (hrd_q == '0);
		sts.atom_match  = (ard_q == key_q);
		sts.probes_last = (probes_q == SLOT_W'(HASH_SLOTS - 1));
		sts.table_full  = (count_q >= CNT_W'(MAX_ATOMS));
		sts.sweep_last  = (sw_q == SLOT_W'(HASH_SLOTS - 1));
	end

	assign atom_index = atom_index_q;
	assign status     = status_q;

endmodule

@@ design/hash_consing_atom_table.sv @@
// Atom unique table, one item at a time. A lookup compares occupied slots in turn and ends
// on a hit, on an empty slot or after the last probe. Clear, and a truncate that drops atoms,
// walk every hash slot. The next item is taken while the previous result still waits in the
// output register. After reset a clearing pass empties the hash slots; in_stall is high until
// it ends. Atom storage is not cleared and is read only below the atom count.
module hash_consing_atom_table #(
	parameter int MAX_ATOMS  = 1024,
	parameter int HASH_SLOTS = 2048,
	parameter int VAR_BITS   = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [hcat_pkg::CMD_W-1:0]     command,
	input  logic [hcat_pkg::KIND_W-1:0]    op_kind,
	input  logic [VAR_BITS-1:0]            left_var,
	input  logic [VAR_BITS-1:0]            right_var,
	input  logic [$clog2(MAX_ATOMS+1)-1:0] keep_count,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [$clog2(MAX_ATOMS)-1:0]   atom_index,
	output logic [hcat_pkg::RES_W-1:0]     status
);
	import hcat_pkg::*;

	dp_cmd_t dcmd;
	dp_sts_t dsts;

	hcat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (dcmd),
		.sts       (dsts)
	);

	hcat_dp #(
		.MAX_ATOMS  (MAX_ATOMS),
		.HASH_SLOTS (HASH_SLOTS),
		.VAR_BITS   (VAR_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.command    (command),
		.op_kind    (op_kind),
		.left_var   (left_var),
		.right_var  (right_var),
		.keep_count (keep_count),
		.cmd        (dcmd),
		.sts        (dsts),
		.atom_index (atom_index),
		.status     (status)
	);

	// One item in flight: accepting an item closes the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in flight");

	// Only found or created results carry an index
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !(status == RES_FOUND || status == RES_CREATED)) |-> (atom_index == '0))
		else $error("nonzero index on a result without an atom");

	// Creation only when an empty slot was seen and the table has room
	assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.create |-> (dsts.slot_empty && !dsts.table_full && !dsts.is_find))
		else $error("atom created without room or on a find");

	// Hash slot walk never overlaps a lookup
	assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.sweep_run |-> !(dcmd.create || dcmd.next_slot || dcmd.load))
		else $error("lookup activity during slot sweep");

endmodule
